FILE: hw/rtl/stt_pkg.sv
// Package for the source text tokenizer: widths, scan modes, token kinds,
// the keyword table and the small helper functions used by the core.
// No dependencies.
`default_nettype none

package stt_pkg;

  // Sizing
  localparam int MAX_TOKEN_LEN = 64;
  localparam int POSITION_BITS = 20;
  localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1);
  localparam int KW_COUNT      = 22;
  localparam int KW_IDX_BITS   = 5;
  localparam int KIND_BITS     = 5;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_BITS-1:0]      MAX_LEN  = LEN_BITS'(MAX_TOKEN_LEN);
  localparam logic [KW_COUNT-1:0]      KW_ALL   = {KW_COUNT{1'b1}};
  localparam logic [POSITION_BITS-1:0] LINE_SAT = {{(POSITION_BITS - 1){1'b1}}, 1'b0};

  // Scan modes
  typedef enum logic [3:0] {
    MODE_START    = 4'd0,
    MODE_ID       = 4'd1,
    MODE_NUM      = 4'd2,
    MODE_EQ       = 4'd3,
    MODE_SLASH    = 4'd4,
    MODE_LINE     = 4'd5,
    MODE_BLOCK    = 4'd6,
    MODE_ID_LONG  = 4'd7,
    MODE_NUM_LONG = 4'd8
  } mode_t;

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_ERROR   = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_HASH    = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_DOLLAR  = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_EQ      = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_DIV     = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_DONE    = 5'd16;

  // Keyword table, text right-justified, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "if", "else", "endif", "for", "while", "switch", "case", "do",
    "break", "continue", "goto", "unsigned", "enum", "typedef", "struct",
    "include", "define", "state", "cts", "stc", "start", "end"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd2, 4'd5, 4'd8, 4'd4,
    4'd8, 4'd4, 4'd7, 4'd6, 4'd7, 4'd6, 4'd5, 4'd3, 4'd3, 4'd5, 4'd3
  };

  // One result item
  typedef struct packed {
    logic [KIND_BITS-1:0]     kind;
    logic [KW_IDX_BITS-1:0]   kw_index;
    logic [POSITION_BITS-1:0] start_ofs;
    logic [LEN_BITS-1:0]      length;
    logic [POSITION_BITS-1:0] line;
    logic                     last;
  } token_t;

  typedef struct packed {
    logic                   hit;
    logic [KW_IDX_BITS-1:0] idx;
  } kw_hit_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Drop candidates that are too short for pos or whose character at pos differs from c
  function automatic logic [KW_COUNT-1:0] kw_narrow(input logic [KW_COUNT-1:0] cand,
                                                    input logic [LEN_BITS-1:0] pos,
                                                    input logic [7:0]          c);
    logic [KW_COUNT-1:0] res;
    int                  sh;
    res = cand;
    sh  = 0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (int'(pos) >= int'(KW_LEN[i])) begin
        res[i] = 1'b0;
      end else begin
        sh = 8 * (int'(KW_LEN[i]) - 1 - int'(pos));
        if (KW_TEXT[i][sh +: 8] != c) begin
          res[i] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // Find the lowest surviving candidate whose length matches exactly
  function automatic kw_hit_t kw_lookup(input logic [KW_COUNT-1:0] cand,
                                        input logic [LEN_BITS-1:0] len);
    kw_hit_t res;
    res = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (cand[i] && (LEN_BITS'(KW_LEN[i]) == len)) begin
        res.hit = 1'b1;
        res.idx = KW_IDX_BITS'(i);
      end
    end
    return res;
  endfunction

  function automatic token_t make_token(input logic [KIND_BITS-1:0]     kind,
                                        input logic [KW_IDX_BITS-1:0]   idx,
                                        input logic [POSITION_BITS-1:0] start_ofs,
                                        input logic [LEN_BITS-1:0]      len,
                                        input logic [POSITION_BITS-1:0] line_cnt);
    token_t t;
    t.kind      = kind;
    t.kw_index  = idx;
    t.start_ofs = start_ofs;
    t.length    = len;
    t.line      = line_cnt + POSITION_BITS'(1);
    t.last      = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/source_text_tokenizer.sv
// Source text tokenizer top level: scan state, keyword mask and token queue.
// Depends on stt_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   text     in         text_valid / text_stall    text_byte
//   token    out        token_valid / token_stall  token_kind, keyword_index,
//                                                  start_offset, lexeme_length,
//                                                  line_number, last_of_run
//
// One byte is taken per cycle while text_stall is low; the scanner finishes
// its work on a byte in the cycle it is accepted and pushes zero, one or two
// tokens into a four-entry queue. Tokens leave the queue one per cycle while
// token_stall is low. text_stall is high while fewer than two queue entries
// are free. Reset (rst, synchronous) empties the queue and returns the
// scanner to its start mode at offset 0, line 1.
`default_nettype none

module source_text_tokenizer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              text_valid,
  output logic                                   text_stall,
  input  wire logic [7:0]                        text_byte,
  output logic                                   token_valid,
  input  wire logic                              token_stall,
  output logic [stt_pkg::KIND_BITS-1:0]          token_kind,
  output logic [stt_pkg::KW_IDX_BITS-1:0]        keyword_index,
  output logic [stt_pkg::POSITION_BITS-1:0]      start_offset,
  output logic [stt_pkg::LEN_BITS-1:0]           lexeme_length,
  output logic [stt_pkg::POSITION_BITS-1:0]      line_number,
  output logic                                   last_of_run
);

  // Scanner state
  stt_pkg::mode_t                          mode, mode_next;
  logic [stt_pkg::KW_COUNT-1:0]            cand, cand_next;
  logic [stt_pkg::LEN_BITS-1:0]            tok_len, tok_len_next;
  logic [stt_pkg::POSITION_BITS-1:0]       tok_start, tok_start_next;
  logic [stt_pkg::POSITION_BITS-1:0]       byte_pos, byte_pos_next;
  logic [stt_pkg::POSITION_BITS-1:0]       line_cnt, line_cnt_next;
  logic [7:0]                              prev_byte, prev_byte_next;

  // Token queue
  stt_pkg::token_t                         queue [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::PTR_BITS-1:0]            wr_ptr, rd_ptr;
  logic [stt_pkg::CNT_BITS-1:0]            fifo_count;

  stt_pkg::token_t                         tok_a, tok_b;
  logic                                    tok_a_v, tok_b_v;
  logic                                    again, was_reset;
  logic                                    text_accept, token_accept;
  stt_pkg::kw_hit_t                        kw_hit;
  logic [7:0]                              c;

  assign c            = text_byte;
  assign text_accept  = text_valid && !text_stall;
  assign token_accept = token_valid && !token_stall;
  assign text_stall   = fifo_count > stt_pkg::CNT_BITS'(stt_pkg::FIFO_DEPTH - 2);
  assign kw_hit       = stt_pkg::kw_lookup(cand, tok_len);

  // Scan one byte: finish the pending lexeme, then rescan from start mode
  always_comb begin
    mode_next      = mode;
    cand_next      = cand;
    tok_len_next   = tok_len;
    tok_start_next = tok_start;
    byte_pos_next  = byte_pos;
    line_cnt_next  = line_cnt;
    prev_byte_next = prev_byte;
    tok_a          = '0;
    tok_b          = '0;
    tok_a_v        = 1'b0;
    tok_b_v        = 1'b0;
    again          = 1'b0;
    was_reset      = 1'b0;

    case (mode)
      stt_pkg::MODE_ID, stt_pkg::MODE_ID_LONG: begin
        if (stt_pkg::is_letter(c) || (c == "_")) begin
          if (mode == stt_pkg::MODE_ID) begin
            if (tok_len < stt_pkg::MAX_LEN) begin
              cand_next    = stt_pkg::kw_narrow(cand, tok_len, c);
              tok_len_next = tok_len + stt_pkg::LEN_BITS'(1);
            end else begin
              mode_next = stt_pkg::MODE_ID_LONG;
            end
          end
        end else begin
          tok_a_v = 1'b1;
          if (mode == stt_pkg::MODE_ID_LONG) begin
            tok_a = stt_pkg::make_token(stt_pkg::KIND_ERROR, '0, tok_start,
                                        stt_pkg::MAX_LEN, line_cnt);
          end else if (kw_hit.hit) begin
            tok_a = stt_pkg::make_token(stt_pkg::KIND_KEYWORD, kw_hit.idx, tok_start,
                                        tok_len, line_cnt);
          end else begin
            tok_a = stt_pkg::make_token(stt_pkg::KIND_IDENT, '0, tok_start,
                                        tok_len, line_cnt);
          end
          mode_next = stt_pkg::MODE_START;
          again     = 1'b1;
        end
        prev_byte_next = c;
      end
      stt_pkg::MODE_NUM, stt_pkg::MODE_NUM_LONG: begin
        if (stt_pkg::is_digit(c) || (c == ".") ||
            (((c == "x") || (c == "X")) && (prev_byte == "0"))) begin
          if (mode == stt_pkg::MODE_NUM) begin
            if (tok_len < stt_pkg::MAX_LEN) begin
              tok_len_next = tok_len + stt_pkg::LEN_BITS'(1);
            end else begin
              mode_next = stt_pkg::MODE_NUM_LONG;
            end
          end
        end else begin
          tok_a_v = 1'b1;
          if (mode == stt_pkg::MODE_NUM_LONG) begin
            tok_a = stt_pkg::make_token(stt_pkg::KIND_ERROR, '0, tok_start,
                                        stt_pkg::MAX_LEN, line_cnt);
          end else begin
            tok_a = stt_pkg::make_token(stt_pkg::KIND_NUMBER, '0, tok_start,
                                        tok_len, line_cnt);
          end
          mode_next = stt_pkg::MODE_START;
          again     = 1'b1;
        end
        prev_byte_next = c;
      end
      stt_pkg::MODE_EQ: begin
        tok_a_v = 1'b1;
        if (c == "=") begin
          tok_a = stt_pkg::make_token(stt_pkg::KIND_EQ, '0, tok_start,
                                      stt_pkg::LEN_BITS'(2), line_cnt);
        end else begin
          tok_a = stt_pkg::make_token(stt_pkg::KIND_ASSIGN, '0, tok_start,
                                      stt_pkg::LEN_BITS'(1), line_cnt);
          again = 1'b1;
        end
        mode_next = stt_pkg::MODE_START;
      end
      stt_pkg::MODE_SLASH: begin
        if (c == "/") begin
          mode_next = stt_pkg::MODE_LINE;
        end else if (c == "*") begin
          mode_next      = stt_pkg::MODE_BLOCK;
          prev_byte_next = 8'd0;
        end else begin
          tok_a_v   = 1'b1;
          tok_a     = stt_pkg::make_token(stt_pkg::KIND_DIV, '0, tok_start,
                                          stt_pkg::LEN_BITS'(1), line_cnt);
          mode_next = stt_pkg::MODE_START;
          again     = 1'b1;
        end
      end
      stt_pkg::MODE_LINE: begin
        if ((c == 8'h0a) || (c == 8'h00)) begin
          mode_next = stt_pkg::MODE_START;
          again     = 1'b1;
        end
      end
      stt_pkg::MODE_BLOCK: begin
        if (c == 8'h00) begin
          mode_next = stt_pkg::MODE_START;
          again     = 1'b1;
        end else if ((c == "/") && (prev_byte == "*")) begin
          mode_next      = stt_pkg::MODE_START;
          prev_byte_next = 8'd0;
        end else begin
          if ((c == 8'h0a) && (line_cnt < stt_pkg::LINE_SAT)) begin
            line_cnt_next = line_cnt + stt_pkg::POSITION_BITS'(1);
          end
          prev_byte_next = c;
        end
      end
      stt_pkg::MODE_START: begin
        again = 1'b1;
      end
      default: begin
        mode_next = stt_pkg::MODE_START;
        again     = 1'b1;
      end
    endcase

    // Start a lexeme at this byte
    if (again) begin
      if ((c == 8'h20) || (c == 8'h09) || (c == 8'h0d)) begin
        // skip blanks
      end else if (c == 8'h0a) begin
        if (line_cnt_next < stt_pkg::LINE_SAT) begin
          line_cnt_next = line_cnt_next + stt_pkg::POSITION_BITS'(1);
        end
      end else if (stt_pkg::is_letter(c)) begin
        mode_next      = stt_pkg::MODE_ID;
        tok_start_next = byte_pos;
        cand_next      = stt_pkg::kw_narrow(stt_pkg::KW_ALL, '0, c);
        tok_len_next   = stt_pkg::LEN_BITS'(1);
        prev_byte_next = c;
      end else if (stt_pkg::is_digit(c)) begin
        mode_next      = stt_pkg::MODE_NUM;
        tok_start_next = byte_pos;
        tok_len_next   = stt_pkg::LEN_BITS'(1);
        prev_byte_next = c;
      end else if (c == "/") begin
        mode_next      = stt_pkg::MODE_SLASH;
        tok_start_next = byte_pos;
      end else if (c == "=") begin
        mode_next      = stt_pkg::MODE_EQ;
        tok_start_next = byte_pos;
      end else if (c == 8'h00) begin
        tok_b_v        = 1'b1;
        tok_b          = stt_pkg::make_token(stt_pkg::KIND_DONE, '0, byte_pos,
                                             '0, line_cnt_next);
        was_reset      = 1'b1;
        mode_next      = stt_pkg::MODE_START;
        cand_next      = stt_pkg::KW_ALL;
        tok_len_next   = '0;
        tok_start_next = '0;
        line_cnt_next  = '0;
        prev_byte_next = 8'd0;
      end else begin
        tok_b_v = 1'b1;
        case (c)
          ":":     tok_b.kind = stt_pkg::KIND_COLON;
          ";":     tok_b.kind = stt_pkg::KIND_SEMI;
          "#":     tok_b.kind = stt_pkg::KIND_HASH;
          "{":     tok_b.kind = stt_pkg::KIND_LBRACE;
          "}":     tok_b.kind = stt_pkg::KIND_RBRACE;
          "(":     tok_b.kind = stt_pkg::KIND_LPAREN;
          ")":     tok_b.kind = stt_pkg::KIND_RPAREN;
          ",":     tok_b.kind = stt_pkg::KIND_COMMA;
          "$":     tok_b.kind = stt_pkg::KIND_DOLLAR;
          default: tok_b.kind = stt_pkg::KIND_ERROR;
        endcase
        tok_b.start_ofs = byte_pos;
        tok_b.length    = stt_pkg::LEN_BITS'(1);
        tok_b.line      = line_cnt_next + stt_pkg::POSITION_BITS'(1);
      end
    end

    // Advance the offset unless end of text reset it
    if (was_reset) begin
      byte_pos_next = '0;
    end else begin
      byte_pos_next = byte_pos + stt_pkg::POSITION_BITS'(1);
    end

    // Mark the final token of this byte
    if (tok_b_v) begin
      tok_b.last = 1'b1;
    end else if (tok_a_v) begin
      tok_a.last = 1'b1;
    end
  end

  // Hold scanner state, update on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= stt_pkg::MODE_START;
      cand      <= stt_pkg::KW_ALL;
      tok_len   <= '0;
      tok_start <= '0;
      byte_pos  <= '0;
      line_cnt  <= '0;
      prev_byte <= 8'd0;
    end else if (text_accept) begin
      mode      <= mode_next;
      cand      <= cand_next;
      tok_len   <= tok_len_next;
      tok_start <= tok_start_next;
      byte_pos  <= byte_pos_next;
      line_cnt  <= line_cnt_next;
      prev_byte <= prev_byte_next;
    end
  end

  // Push up to two tokens, in order
  always_ff @(posedge clk) begin
    if (text_accept) begin
      if (tok_a_v) begin
        queue[wr_ptr] <= tok_a;
      end
      if (tok_b_v) begin
        queue[wr_ptr + stt_pkg::PTR_BITS'(tok_a_v)] <= tok_b;
      end
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (text_accept) begin
        wr_ptr <= wr_ptr + stt_pkg::PTR_BITS'(tok_a_v) + stt_pkg::PTR_BITS'(tok_b_v);
      end
      if (token_accept) begin
        rd_ptr <= rd_ptr + stt_pkg::PTR_BITS'(1);
      end
      fifo_count <= fifo_count
                  + stt_pkg::CNT_BITS'(text_accept && tok_a_v)
                  + stt_pkg::CNT_BITS'(text_accept && tok_b_v)
                  - stt_pkg::CNT_BITS'(token_accept);
    end
  end

  // Present the queue head
  assign token_valid   = fifo_count != '0;
  assign token_kind    = queue[rd_ptr].kind;
  assign keyword_index = queue[rd_ptr].kw_index;
  assign start_offset  = queue[rd_ptr].start_ofs;
  assign lexeme_length = queue[rd_ptr].length;
  assign line_number   = queue[rd_ptr].line;
  assign last_of_run   = queue[rd_ptr].last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= stt_pkg::CNT_BITS'(stt_pkg::FIFO_DEPTH))
    else $error("token queue overfilled");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    text_accept |-> (fifo_count <= stt_pkg::CNT_BITS'(stt_pkg::FIFO_DEPTH - 2)))
    else $error("byte taken without room for two tokens");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (fifo_count == '0) && (mode == stt_pkg::MODE_START))
    else $error("reset left queue or scanner busy");

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_kind == stt_pkg::KIND_DONE)) |->
      ((lexeme_length == '0) && last_of_run))
    else $error("end-of-text token malformed");

  a_kw_index: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_kind != stt_pkg::KIND_KEYWORD)) |-> (keyword_index == '0))
    else $error("keyword index set on a non-keyword token");

endmodule

`default_nettype wire
